// File: rtl/core/utf8_dfa_decoder_macros.svh
// assertion macros for the utf8 dfa decoder
`ifndef UTF8_DFA_DECODER_MACROS_SVH
`define UTF8_DFA_DECODER_MACROS_SVH

// checked on every clock edge outside reset
`define U8DFA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("u8dfa assertion failed");

// checked on every clock edge, reset included
`define U8DFA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("u8dfa assertion failed");

`endif

// File: rtl/core/u8dfa_pkg.sv
// types, constants and tables of the utf8 dfa decoder
`default_nettype none

package u8dfa_pkg;

   localparam int unsigned BYTE_BITS  = 8;
   localparam int unsigned STATE_BITS = 4;
   localparam int unsigned CLASS_BITS = 4;
   localparam int unsigned POINT_BITS = 21;
   localparam int unsigned OUT_COUNT_BITS = 16;
   localparam int unsigned NUM_STATES = 9;
   localparam int unsigned NUM_CLASSES = 16;

   localparam logic [STATE_BITS-1:0] ST_ACCEPT = 4'd0;
   localparam logic [STATE_BITS-1:0] ST_REJECT = 4'd1;
   localparam logic [STATE_BITS-1:0] ST_LAST   = 4'd8;

   localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = 16'hFFFF;
   localparam logic [BYTE_BITS-1:0] LEAD_MASK = 8'hFF;
   localparam logic [BYTE_BITS-1:0] CONT_MASK = 8'h3F;

   // character classes
   localparam logic [CLASS_BITS-1:0] CLS_ASCII    = 4'd0;
   localparam logic [CLASS_BITS-1:0] CLS_CONT_LO  = 4'd1;
   localparam logic [CLASS_BITS-1:0] CLS_LEAD2    = 4'd2;
   localparam logic [CLASS_BITS-1:0] CLS_LEAD3    = 4'd3;
   localparam logic [CLASS_BITS-1:0] CLS_ED       = 4'd4;
   localparam logic [CLASS_BITS-1:0] CLS_F4       = 4'd5;
   localparam logic [CLASS_BITS-1:0] CLS_LEAD4    = 4'd6;
   localparam logic [CLASS_BITS-1:0] CLS_CONT_HI  = 4'd7;
   localparam logic [CLASS_BITS-1:0] CLS_INVALID  = 4'd8;
   localparam logic [CLASS_BITS-1:0] CLS_CONT_MID = 4'd9;
   localparam logic [CLASS_BITS-1:0] CLS_E0       = 4'd10;
   localparam logic [CLASS_BITS-1:0] CLS_F0       = 4'd11;

   // transition table, one row per state, one column per class
   localparam logic [STATE_BITS-1:0] NEXT_STATE [NUM_STATES][NUM_CLASSES] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
        4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
        4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
   };

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 last_byte;
   } req_type;

   typedef struct packed {
      logic [POINT_BITS-1:0]     code_point;
      logic                      code_valid;
      logic                      at_end;
      logic                      malformed;
      logic [OUT_COUNT_BITS-1:0] code_count;
   } rsp_type;

   // what one decode step leaves behind
   typedef struct packed {
      logic [STATE_BITS-1:0] state;
      logic [POINT_BITS-1:0] accum;
      logic                  done;
   } step_type;

   function automatic logic [CLASS_BITS-1:0] byte_class(input logic [BYTE_BITS-1:0] b);
      logic [CLASS_BITS-1:0] cls;
      cls = CLS_INVALID;
      case (b) inside
         [8'h00:8'h7F]: cls = CLS_ASCII;
         [8'h80:8'h8F]: cls = CLS_CONT_LO;
         [8'h90:8'h9F]: cls = CLS_CONT_MID;
         [8'hA0:8'hBF]: cls = CLS_CONT_HI;
         [8'hC2:8'hDF]: cls = CLS_LEAD2;
         8'hE0:         cls = CLS_E0;
         8'hED:         cls = CLS_ED;
         [8'hE1:8'hEC],
         [8'hEE:8'hEF]: cls = CLS_LEAD3;
         8'hF0:         cls = CLS_F0;
         [8'hF1:8'hF3]: cls = CLS_LEAD4;
         8'hF4:         cls = CLS_F4;
         default:       cls = CLS_INVALID;
      endcase
      return cls;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/u8dfa_step.sv
// one automaton step: byte class, state transition and code point accumulation
`default_nettype none

module u8dfa_step (
   input  wire logic [u8dfa_pkg::STATE_BITS-1:0] state,
   input  wire logic [u8dfa_pkg::POINT_BITS-1:0] accum,
   input  wire logic [u8dfa_pkg::BYTE_BITS-1:0]  data_byte,
   output u8dfa_pkg::step_type                    step
);
   import u8dfa_pkg::*;

   logic [CLASS_BITS-1:0] cls;
   logic [STATE_BITS-1:0] cur;
   logic [BYTE_BITS-1:0]  lead_bits;

   always_comb begin
      cls = byte_class(data_byte);
      // unused codes behave as reject
      cur = (state > ST_LAST) ? ST_REJECT : state;
      lead_bits = (LEAD_MASK >> cls) & data_byte;
      if (cur != ST_ACCEPT) begin
         step.accum = {accum[POINT_BITS-7:0], data_byte[5:0] & CONT_MASK[5:0]};
      end else begin
         step.accum = {{(POINT_BITS-BYTE_BITS){1'b0}}, lead_bits};
      end
      step.state = NEXT_STATE[cur][cls];
      step.done  = (step.state == ST_ACCEPT);
   end

endmodule

`default_nettype wire

// File: rtl/core/utf8_dfa_decoder.sv
// utf8 dfa decoder top level: input register, decode step and result register
// a word enters the input register on acceptance, its result is loaded into the
//   result register when the word advances, and rsp shows that register
// throughput: one byte per cycle unless a result is held up, set by the state loop
// reset: synchronous, clears both valid flags, the automaton, accumulator and count
`default_nettype none

module utf8_dfa_decoder #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire u8dfa_pkg::req_type req_word,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      u8dfa_pkg::rsp_type rsp_word
);
   import u8dfa_pkg::*;

`include "utf8_dfa_decoder_macros.svh"

   // count compare width, wide enough for the reported field too
   localparam int unsigned EXT_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS
                                                                     : OUT_COUNT_BITS;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_word_ff, in_word_in;

   // decoder state
   logic [STATE_BITS-1:0] state_ff, state_in;
   logic [POINT_BITS-1:0] accum_ff, accum_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_word_ff, rsp_word_in;

   step_type              step;
   logic                  req_take;
   logic                  out_blocked;
   logic                  advance;
   logic                  emit;
   logic                  bad;
   logic [COUNT_BITS-1:0] count_step;
   logic [EXT_BITS-1:0]   count_ext;
   logic [OUT_COUNT_BITS-1:0] count_report;

   // the input register only waits when a result is held up downstream
   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign req_stall   = in_valid_ff && out_blocked;
   assign req_take    = req_valid && !req_stall;
   assign advance     = in_valid_ff && !out_blocked;

   u8dfa_step u_step (
      .state     (state_ff),
      .accum     (accum_ff),
      .data_byte (in_word_ff.data_byte),
      .step      (step)
   );

   // input stage
   always_comb begin
      in_word_in = in_word_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // state update and result formation
   always_comb begin
      // count saturates at all ones
      count_step = (step.done && (count_ff != '1)) ? count_ff + 1'b1 : count_ff;
      count_ext  = EXT_BITS'(count_step);
      count_report = (count_ext > EXT_BITS'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                            : count_ext[OUT_COUNT_BITS-1:0];
      bad  = (step.state != ST_ACCEPT);
      emit = step.done || in_word_ff.last_byte;

      state_in = state_ff;
      accum_in = accum_ff;
      count_in = count_ff;
      if (advance) begin
         if (in_word_ff.last_byte) begin
            // string ends: start the next one from scratch
            state_in = ST_ACCEPT;
            accum_in = '0;
            count_in = '0;
         end else begin
            state_in = step.state;
            accum_in = step.accum;
            count_in = count_step;
         end
      end

      rsp_word_in.code_point = step.done ? step.accum : '0;
      rsp_word_in.code_valid = step.done;
      rsp_word_in.at_end     = in_word_ff.last_byte;
      rsp_word_in.malformed  = in_word_ff.last_byte && bad;
      rsp_word_in.code_count = (in_word_ff.last_byte && !bad) ? count_report : '0;
   end

   // result stage
   always_comb begin
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_ACCEPT;
         accum_ff     <= '0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         accum_ff     <= accum_in;
         count_ff     <= count_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
      if (advance && emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a completed code point and a malformed end never share one word
   `U8DFA_ASSERT(a_valid_not_bad, clock, reset,
      rsp_valid_ff |-> !(rsp_word_ff.code_valid && rsp_word_ff.malformed))
   // a malformed string reports no code points
   `U8DFA_ASSERT(a_bad_zero_count, clock, reset,
      (rsp_valid_ff && rsp_word_ff.malformed) |-> (rsp_word_ff.code_count == '0))
   // a word that does not end the string always carries a code point
   `U8DFA_ASSERT(a_mid_has_point, clock, reset,
      (rsp_valid_ff && !rsp_word_ff.at_end) |-> rsp_word_ff.code_valid)
   // after the final byte the decoder starts clean
   `U8DFA_ASSERT(a_end_clears, clock, reset,
      (advance && in_word_ff.last_byte) |=> (state_ff == ST_ACCEPT && count_ff == '0))
   // nothing pending right after reset
   `U8DFA_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> (!rsp_valid_ff && !in_valid_ff))

endmodule

`default_nettype wire
